FILE: rtl/core/ttf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and controller codes for the triangle tangent frame block.
package ttf_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int OUT_WIDTH_DEF   = 16;

  // Shared multiplier operand width and the width of products and sums.
  localparam int MUL_W = 32;
  localparam int ACC_W = 64;

  // Multiplier step indexes: fourteen cross products, then three squares.
  localparam logic [4:0] MI_LAST_CROSS = 5'd13;
  localparam logic [4:0] MI_SQ_FIRST   = 5'd14;
  localparam logic [3:0] MUL_DRAIN     = 4'd14;

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SIGN,
    S_NLOAD,
    S_NSHIFT,
    S_SQ,
    S_SQRT,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       store0;
    logic       store1;
    logic       load_delta;
    logic       mul_go;
    logic [4:0] mul_idx;
    logic       sign_fix;
    logic       vec_sel;
    logic       norm_load;
    logic       norm_shift;
    logic       sqrt_init;
    logic       sqrt_step;
    logic [4:0] sqrt_j;
    logic [1:0] comp;
    logic       div_init;
    logic       div_step;
    logic [5:0] div_k;
    logic       div_store;
  } cmd_t;

  typedef struct packed {
    logic deg;
    logic norm_done;
  } sts_t;

endpackage

FILE: rtl/core/ttf_vtx_if.sv
`timescale 1ns / 1ps
// Vertex channel interface: valid, ready and one vertex word.
interface ttf_vtx_if #(
  parameter int CW = ttf_pkg::COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic signed [CW-1:0] tex_u;
  logic signed [CW-1:0] tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

FILE: rtl/core/ttf_frame_if.sv
`timescale 1ns / 1ps
// Result channel interface: valid, ready and one tangent frame word.
interface ttf_frame_if #(
  parameter int OW = ttf_pkg::OUT_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] tan_x;
  logic signed [OW-1:0] tan_y;
  logic signed [OW-1:0] tan_z;
  logic signed [OW-1:0] bitan_x;
  logic signed [OW-1:0] bitan_y;
  logic signed [OW-1:0] bitan_z;
  logic                 degenerate;

  modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, degenerate,
                  input ready);
  modport sink (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, degenerate,
                output ready);
endinterface

FILE: rtl/core/ttf_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: vertex phase, step sequencing and result handshake.
module ttf_ctrl #(
  parameter int OUT_WIDTH = ttf_pkg::OUT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ttf_pkg::sts_t sts,
  output ttf_pkg::cmd_t cmd
);

  localparam logic [5:0] DIV_END = 6'(OUT_WIDTH + 1);
  // A divider step at count c tries the root shifted left by OUT_WIDTH - c.
  localparam logic [5:0] DIV_TOP = 6'(OUT_WIDTH);

  ttf_pkg::state_t state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       vec_r, vec_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;

  assign in_ready  = (state_r == ttf_pkg::S_IDLE) &&
                     ((phase_r != ttf_pkg::PHASE_THIRD) || !out_valid_r);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttf_pkg::S_IDLE;
      phase_r     <= ttf_pkg::PHASE_FIRST;
      cnt_r       <= '0;
      vec_r       <= 1'b0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      vec_r       <= vec_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    vec_nxt       = vec_r;
    comp_nxt      = comp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.vec_sel   = vec_r;
    cmd.comp      = comp_r;
    cmd.mul_idx   = cnt_r[4:0];
    cmd.sqrt_j    = ~cnt_r[4:0];
    cmd.div_k     = DIV_TOP - cnt_r;

    case (state_r)
      ttf_pkg::S_IDLE: begin
        if (in_acc) begin
          case (phase_r)
            ttf_pkg::PHASE_FIRST: begin
              cmd.store0 = 1'b1;
              phase_nxt  = ttf_pkg::PHASE_SECOND;
            end
            ttf_pkg::PHASE_SECOND: begin
              cmd.store1 = 1'b1;
              phase_nxt  = ttf_pkg::PHASE_THIRD;
            end
            default: begin
              cmd.load_delta = 1'b1;
              phase_nxt      = ttf_pkg::PHASE_FIRST;
              state_nxt      = ttf_pkg::S_MUL;
              cnt_nxt        = '0;
            end
          endcase
        end
      end
      ttf_pkg::S_MUL: begin
        // The last count only lets the final product reach the accumulator.
        if (cnt_r[3:0] == ttf_pkg::MUL_DRAIN) begin
          state_nxt = ttf_pkg::S_SIGN;
        end else begin
          cmd.mul_go = 1'b1;
          cnt_nxt    = cnt_r + 6'd1;
        end
      end
      ttf_pkg::S_SIGN: begin
        cmd.sign_fix = 1'b1;
        vec_nxt      = 1'b0;
        state_nxt    = sts.deg ? ttf_pkg::S_DONE : ttf_pkg::S_NLOAD;
      end
      ttf_pkg::S_NLOAD: begin
        cmd.norm_load = 1'b1;
        state_nxt     = ttf_pkg::S_NSHIFT;
      end
      ttf_pkg::S_NSHIFT: begin
        if (sts.norm_done) begin
          state_nxt = ttf_pkg::S_SQ;
          cnt_nxt   = '0;
        end else begin
          cmd.norm_shift = 1'b1;
        end
      end
      ttf_pkg::S_SQ: begin
        cmd.mul_idx = ttf_pkg::MI_SQ_FIRST + cnt_r[4:0];
        if (cnt_r < 6'd3) begin
          cmd.mul_go = 1'b1;
          cnt_nxt    = cnt_r + 6'd1;
        end else if (cnt_r == 6'd3) begin
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          cmd.sqrt_init = 1'b1;
          state_nxt     = ttf_pkg::S_SQRT;
          cnt_nxt       = '0;
        end
      end
      ttf_pkg::S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == 6'd31) begin
          state_nxt = ttf_pkg::S_DIV;
          cnt_nxt   = '0;
          comp_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ttf_pkg::S_DIV: begin
        if (cnt_r == 6'd0) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = cnt_r + 6'd1;
        end else if (cnt_r != DIV_END) begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 6'd1;
        end else begin
          cmd.div_store = 1'b1;
          cnt_nxt       = '0;
          if (comp_r == 2'd2) begin
            if (vec_r) begin
              state_nxt = ttf_pkg::S_DONE;
            end else begin
              vec_nxt   = 1'b1;
              state_nxt = ttf_pkg::S_NLOAD;
            end
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
      end
      ttf_pkg::S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ttf_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ttf_pkg::S_IDLE;
      end
    endcase
  end

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("vertex phase left its range");

  a_third_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == ttf_pkg::PHASE_THIRD) |=> state_r == ttf_pkg::S_MUL)
    else $error("third vertex did not start the computation");

  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ttf_pkg::S_DONE |=> out_valid_r)
    else $error("finished frame not presented");

  a_deg_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttf_pkg::S_SIGN && sts.deg) |=> state_r == ttf_pkg::S_DONE)
    else $error("degenerate triangle went on to normalization");

endmodule

FILE: rtl/core/ttf_dp.sv
`timescale 1ns / 1ps
// Datapath: held vertices, deltas, shared multiplier, normalizer, square root and divider.
module ttf_dp #(
  parameter int COORD_WIDTH = ttf_pkg::COORD_WIDTH_DEF,
  parameter int OUT_WIDTH   = ttf_pkg::OUT_WIDTH_DEF
) (
  input  logic                          clk,
  input  ttf_pkg::cmd_t                 cmd,
  output ttf_pkg::sts_t                 sts,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic signed [COORD_WIDTH-1:0] tex_u,
  input  logic signed [COORD_WIDTH-1:0] tex_v,
  output logic signed [OUT_WIDTH-1:0]   tan_x,
  output logic signed [OUT_WIDTH-1:0]   tan_y,
  output logic signed [OUT_WIDTH-1:0]   tan_z,
  output logic signed [OUT_WIDTH-1:0]   bitan_x,
  output logic signed [OUT_WIDTH-1:0]   bitan_y,
  output logic signed [OUT_WIDTH-1:0]   bitan_z,
  output logic                          degenerate
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = (CW > 30) ? 31 : CW + 1;
  localparam int DROP  = (CW > 30) ? CW - 30 : 0;
  localparam int FRAC  = OUT_WIDTH - 2;
  localparam int AW    = ttf_pkg::ACC_W;
  localparam int MW    = ttf_pkg::MUL_W;
  localparam logic [AW-1:0] NORM_HIGH = AW'(1) << 30;
  localparam logic [AW-1:0] NORM_LOW  = AW'(1) << 29;

  // Difference of two coordinates, truncated toward zero by DROP bits.
  function automatic logic signed [DW-1:0] delta(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [CW:0] df;
    logic [CW:0]        mg;
    logic [CW:0]        sh;
    df = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    mg = df[CW] ? (~df + 1'b1) : df;
    sh = mg >> DROP;
    if (df[CW]) begin
      sh = ~sh + 1'b1;
    end
    return DW'(sh);
  endfunction

  logic signed [CW-1:0] hp0_r [3];
  logic signed [CW-1:0] hp1_r [3];
  logic signed [CW-1:0] ht0_r [2];
  logic signed [CW-1:0] ht1_r [2];
  logic signed [DW-1:0] e1_r [3];
  logic signed [DW-1:0] e2_r [3];
  logic signed [DW-1:0] du1_r, dv1_r, du2_r, dv2_r;

  logic signed [MW-1:0] ma, mb;
  logic signed [AW-1:0] prod_r, acc_r;
  logic [4:0]           idx_r;
  logic                 vld_r;
  // Entry 0 is the determinant, 1..3 the tangent and 4..6 the bitangent.
  logic signed [AW-1:0] res_r [7];
  logic [AW-1:0]        sum_r;

  logic [AW-1:0] m_r [3];
  logic          sg_r [3];
  logic [AW-1:0] big;

  logic [AW-1:0] sn_r, root_r, sbit, stry;
  logic [AW-1:0] rem_r, dsh;
  logic [OUT_WIDTH-1:0] q_r, qs;
  logic signed [OUT_WIDTH-1:0] outv_r [6];
  logic deg_r;
  logic tz, bz;

  logic signed [CW-1:0] pin [3];
  assign pin[0] = pos_x;
  assign pin[1] = pos_y;
  assign pin[2] = pos_z;

  always_ff @(posedge clk) begin
    if (cmd.store0) begin
      for (int i = 0; i < 3; i++) hp0_r[i] <= pin[i];
      ht0_r[0] <= tex_u;
      ht0_r[1] <= tex_v;
    end
    if (cmd.store1) begin
      for (int i = 0; i < 3; i++) hp1_r[i] <= pin[i];
      ht1_r[0] <= tex_u;
      ht1_r[1] <= tex_v;
    end
    if (cmd.load_delta) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= delta(hp1_r[i], hp0_r[i]);
        e2_r[i] <= delta(pin[i], hp0_r[i]);
      end
      du1_r <= delta(ht1_r[0], ht0_r[0]);
      dv1_r <= delta(ht1_r[1], ht0_r[1]);
      du2_r <= delta(tex_u, ht0_r[0]);
      dv2_r <= delta(tex_v, ht0_r[1]);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_idx)
      5'd0:  begin ma = MW'(du1_r); mb = MW'(dv2_r);   end
      5'd1:  begin ma = MW'(dv1_r); mb = MW'(du2_r);   end
      5'd2:  begin ma = MW'(dv2_r); mb = MW'(e1_r[0]); end
      5'd3:  begin ma = MW'(dv1_r); mb = MW'(e2_r[0]); end
      5'd4:  begin ma = MW'(dv2_r); mb = MW'(e1_r[1]); end
      5'd5:  begin ma = MW'(dv1_r); mb = MW'(e2_r[1]); end
      5'd6:  begin ma = MW'(dv2_r); mb = MW'(e1_r[2]); end
      5'd7:  begin ma = MW'(dv1_r); mb = MW'(e2_r[2]); end
      5'd8:  begin ma = MW'(du1_r); mb = MW'(e2_r[0]); end
      5'd9:  begin ma = MW'(du2_r); mb = MW'(e1_r[0]); end
      5'd10: begin ma = MW'(du1_r); mb = MW'(e2_r[1]); end
      5'd11: begin ma = MW'(du2_r); mb = MW'(e1_r[1]); end
      5'd12: begin ma = MW'(du1_r); mb = MW'(e2_r[2]); end
      5'd13: begin ma = MW'(du2_r); mb = MW'(e1_r[2]); end
      5'd14: begin ma = $signed(m_r[0][MW-1:0]); mb = $signed(m_r[0][MW-1:0]); end
      5'd15: begin ma = $signed(m_r[1][MW-1:0]); mb = $signed(m_r[1][MW-1:0]); end
      5'd16: begin ma = $signed(m_r[2][MW-1:0]); mb = $signed(m_r[2][MW-1:0]); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign tz  = (res_r[1] == '0) && (res_r[2] == '0) && (res_r[3] == '0);
  assign bz  = (res_r[4] == '0) && (res_r[5] == '0) && (res_r[6] == '0);
  assign sts.deg = (res_r[0] == '0) || tz || bz;

  always_comb begin
    big = m_r[0];
    if (m_r[1] > big) big = m_r[1];
    if (m_r[2] > big) big = m_r[2];
  end
  assign sts.norm_done = (big < NORM_HIGH) && (big >= NORM_LOW);

  assign sbit = AW'(1) << {cmd.sqrt_j, 1'b0};
  assign stry = root_r + sbit;
  assign dsh  = root_r << cmd.div_k;
  assign qs   = sg_r[cmd.comp] ? (~q_r + 1'b1) : q_r;

  always_ff @(posedge clk) begin
    vld_r <= cmd.mul_go;
    idx_r <= cmd.mul_idx;
    if (cmd.mul_go) begin
      prod_r <= ma * mb;
    end
    // Cross products are paired: the even one starts a difference, the odd one ends it; squares are summed.
    if (vld_r) begin
      if (idx_r <= ttf_pkg::MI_LAST_CROSS) begin
        if (!idx_r[0]) begin
          acc_r <= prod_r;
        end else begin
          res_r[idx_r[3:1]] <= acc_r - prod_r;
        end
      end else if (idx_r == ttf_pkg::MI_SQ_FIRST) begin
        sum_r <= prod_r;
      end else begin
        sum_r <= sum_r + prod_r;
      end
    end

    if (cmd.sign_fix) begin
      deg_r <= sts.deg;
      if (res_r[0] < 0) begin
        for (int i = 1; i < 7; i++) res_r[i] <= -res_r[i];
      end
      if (sts.deg) begin
        for (int i = 0; i < 6; i++) outv_r[i] <= '0;
      end
    end

    if (cmd.norm_load) begin
      for (int i = 0; i < 3; i++) begin
        sg_r[i] <= cmd.vec_sel ? res_r[4+i][AW-1] : res_r[1+i][AW-1];
        m_r[i]  <= cmd.vec_sel ?
                   (res_r[4+i][AW-1] ? AW'(-res_r[4+i]) : AW'(res_r[4+i])) :
                   (res_r[1+i][AW-1] ? AW'(-res_r[1+i]) : AW'(res_r[1+i]));
      end
    end else if (cmd.norm_shift) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i] <= (big >= NORM_HIGH) ? (m_r[i] >> 1) : (m_r[i] << 1);
      end
    end

    if (cmd.sqrt_init) begin
      sn_r   <= sum_r;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      if (sn_r >= stry) begin
        sn_r   <= sn_r - stry;
        root_r <= (root_r >> 1) + sbit;
      end else begin
        root_r <= root_r >> 1;
      end
    end

    // Restoring division, one quotient bit a cycle from the top.
    if (cmd.div_init) begin
      rem_r <= (m_r[cmd.comp] << FRAC) + (root_r >> 1);
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dsh) begin
        rem_r <= rem_r - dsh;
        q_r   <= {q_r[OUT_WIDTH-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[OUT_WIDTH-2:0], 1'b0};
      end
    end
    if (cmd.div_store) begin
      outv_r[3'(cmd.comp) + (cmd.vec_sel ? 3'd3 : 3'd0)] <= qs;
    end
  end

  assign tan_x      = outv_r[0];
  assign tan_y      = outv_r[1];
  assign tan_z      = outv_r[2];
  assign bitan_x    = outv_r[3];
  assign bitan_y    = outv_r[4];
  assign bitan_z    = outv_r[5];
  assign degenerate = deg_r;

endmodule

FILE: rtl/core/triangle_tangent_frame.sv
`timescale 1ns / 1ps
// Top level of the per-triangle tangent and bitangent unit.
//
//   channel | direction | word
//   in_ch   | in        | one vertex: pos_x/y/z (Q7.8), tex_u/v (Q3.12)
//   out_ch  | out       | one frame: tan_x/y/z, bitan_x/y/z (Q1.14), degenerate
//
// The first two vertices of a triangle are held in registers. The third starts the
// sequence in the controller: 14 products through one shared 32x32 multiplier
// and a sign step, then per vector a normalizing shift of one bit a cycle, 3 squares, a
// 32-step square root and three OUT_WIDTH-step divisions; a degenerate triangle
// goes from the sign step straight to the finished frame.
// Reset is synchronous and active low.
// A finished frame waits in the output registers; the first two vertices of the next
// triangle are still taken, the third waits until the frame has been taken.
module triangle_tangent_frame #(
  parameter int COORD_WIDTH = ttf_pkg::COORD_WIDTH_DEF,
  parameter int OUT_WIDTH   = ttf_pkg::OUT_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ttf_vtx_if.sink     in_ch,
  ttf_frame_if.source out_ch
);

  ttf_pkg::cmd_t cmd;
  ttf_pkg::sts_t sts;

  ttf_ctrl #(
    .OUT_WIDTH (OUT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttf_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .OUT_WIDTH   (OUT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .pos_x      (in_ch.pos_x),
    .pos_y      (in_ch.pos_y),
    .pos_z      (in_ch.pos_z),
    .tex_u      (in_ch.tex_u),
    .tex_v      (in_ch.tex_v),
    .tan_x      (out_ch.tan_x),
    .tan_y      (out_ch.tan_y),
    .tan_z      (out_ch.tan_z),
    .bitan_x    (out_ch.bitan_x),
    .bitan_y    (out_ch.bitan_y),
    .bitan_z    (out_ch.bitan_z),
    .degenerate (out_ch.degenerate)
  );

endmodule
